// ===== hw/rtl/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg
// Shared constants for the sync-word packet deframer: sync pattern, CRC-16
// parameters and the frame position codes.
// ----------------------------------------------------------------------------
package swd_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND = 8'h55;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CRC_W       = 16;
	localparam int unsigned TEMP_W      = 32;
	localparam int unsigned PHASE_W     = 3;

	// Frame position: the body byte expected next (PH_HUNT while hunting for sync)
	localparam logic [PHASE_W-1:0] PH_HUNT   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SEQ    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TEMP0  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_TEMP3  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_CRC_LO = 3'd6;
	localparam logic [PHASE_W-1:0] PH_CRC_HI = 3'd7;

endpackage

// ===== hw/rtl/sync_word_packet_deframer_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_crc16_unit
// Takes received serial bytes, locks onto the 0xAA 0x55 sync pair and checks
// each following seven-byte packet (sequence, four temperature bytes, CRC low
// then high) against a CRC-16/0x1021 with init 0xFFFF over the five payload
// bytes. One result transaction leaves per packet, good or bad. The block
// accepts one byte every cycle while input is not stalled; a byte is
// registered at the input and its effect (including the full byte-wide CRC
// update) lands in the state and result registers when it moves on from
// that input register. Input only stalls when a finished result is still
// waiting in the output register and the registered byte would make the
// next one. Sync bytes inside a packet are payload; after a packet the hunt
// restarts with no remembered byte.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_crc16_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [swd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        packet_ok,
	output logic [swd_pkg::BYTE_W-1:0]  seq_number,
	output logic [swd_pkg::TEMP_W-1:0]  temp_bits,
	output logic [swd_pkg::BYTE_W-1:0]  drop_count
);
	import swd_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic [BYTE_W-1:0]   prev_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CRC_W-1:0]    crc_q;
	logic [BYTE_W-1:0]   seq_q;
	logic [TEMP_W-1:0]   temp_q;
	logic [BYTE_W-1:0]   crc_lo_q;
	logic [BYTE_W-1:0]   exp_seq_q;

	logic                out_valid_q;
	logic                ok_q;
	logic [BYTE_W-1:0]   seq_out_q;
	logic [TEMP_W-1:0]   temp_out_q;
	logic [BYTE_W-1:0]   drop_q;

	logic [CRC_W-1:0]    crc_next;
	logic                emits;
	logic                advance;
	logic                crc_match;

	// CRC of the registered byte
	swd_crc_byte u_crc (
		.acc  (crc_q),
		.data (byte_s1),
		.crc  (crc_next)
	);

	// stage 1 moves on unless it would overwrite a waiting result
	assign emits     = valid_s1 && (phase_q == PH_CRC_HI);
	assign advance   = valid_s1 && (!emits || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign crc_match = ({byte_s1, crc_lo_q} == crc_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			phase_q   <= PH_HUNT;
			crc_q     <= CRC_INIT;
			seq_q     <= '0;
			temp_q    <= '0;
			crc_lo_q  <= '0;
			exp_seq_q <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_HUNT: begin
					if (prev_q == SYNC_FIRST && byte_s1 == SYNC_SECOND) begin
						phase_q <= PH_SEQ;
						crc_q   <= CRC_INIT;
					end else begin
						prev_q  <= byte_s1;
					end
				end
				PH_CRC_LO: begin
					crc_lo_q <= byte_s1;
					phase_q  <= PH_CRC_HI;
				end
				PH_CRC_HI: begin
					if (crc_match) begin
						exp_seq_q <= seq_q + 8'd1;
					end
					phase_q <= PH_HUNT;
					prev_q  <= '0;
					crc_q   <= CRC_INIT;
				end
				default: begin
					// sequence or temperature byte
					crc_q   <= crc_next;
					phase_q <= phase_q + 3'd1;
					if (phase_q == PH_SEQ) begin
						seq_q <= byte_s1;
					end else begin
						temp_q <= {byte_s1, temp_q[TEMP_W-1:BYTE_W]};
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emits) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emits) begin
			ok_q       <= crc_match;
			seq_out_q  <= seq_q;
			temp_out_q <= temp_q;
			drop_q     <= crc_match ? (seq_q - exp_seq_q) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign packet_ok  = ok_q;
	assign seq_number = seq_out_q;
	assign temp_bits  = temp_out_q;
	assign drop_count = drop_q;

	// checks
	a_load_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(phase_q == PH_CRC_HI))
		else $error("result loaded outside the last CRC byte");

	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emits) |=> (phase_q == PH_HUNT && prev_q == '0))
		else $error("hunt not restarted after packet");

	a_bad_no_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !packet_ok) |-> (drop_count == '0))
		else $error("drop count set on a bad packet");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("waiting result lost");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty stage");

endmodule

// ===== hw/rtl/swd_crc_byte.sv =====
// ----------------------------------------------------------------------------
// swd_crc_byte
// One byte of CRC-16 (poly 0x1021, MSB first, no reflection), fully unrolled.
// ----------------------------------------------------------------------------
module swd_crc_byte (
	input  logic [swd_pkg::CRC_W-1:0]  acc,
	input  logic [swd_pkg::BYTE_W-1:0] data,
	output logic [swd_pkg::CRC_W-1:0]  crc
);
	import swd_pkg::*;

	// eight shift/xor steps on a 16-bit value
	always_comb begin
		logic [CRC_W-1:0] c;
		c = acc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		crc = c;
	end

endmodule
